### hdl/pno_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the fractal Perlin noise core: widths, register
// indexes, the permutation table and the gradient select. No dependencies.
package pno_pkg;

   // Fixed-point format of coordinates, fades and gradients
   localparam int FRAC_BITS   = 16;
   localparam int ONE         = 1 << FRAC_BITS;

   // Permutation table
   localparam int TABLE_SIZE  = 256;
   localparam int IDX_W       = $clog2(TABLE_SIZE);

   // Default octave limit handed to the top level
   localparam int MAX_OCTAVES_DEF = 8;

   // Datapath widths
   localparam int POINT_W     = 32;
   localparam int COORD_W     = FRAC_BITS + IDX_W;
   localparam int FR_W        = FRAC_BITS + 2;
   localparam int GRAD_W      = FRAC_BITS + 4;
   localparam int MUL_W       = FRAC_BITS + 6;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int SUM_W       = PROD_W - FRAC_BITS;
   localparam int TOTAL_W     = 40;
   localparam int AMP_W       = FRAC_BITS + 1;
   localparam int AMP_SUM_W   = AMP_W + 4;
   localparam int NOISE_W     = 18;
   localparam int NOISE_MAX   = 131071;
   localparam int NOISE_MIN_MAG = 131072;

   // Configuration port
   localparam int OCT_CNT_W   = 4;
   localparam int PERSIST_W   = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE  = 1'd1;
   localparam logic [OCT_CNT_W-1:0] OCT_CNT_RESET    = 4'd1;
   localparam logic [PERSIST_W-1:0] PERSIST_RESET    = 16'd32768;

   localparam logic [IDX_W-1:0] PERM_TABLE [TABLE_SIZE] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
      8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
      8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
      8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
      8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
      8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
      8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
      8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
      8'd215,8'd61,8'd156,8'd180
   };

   function automatic logic [IDX_W-1:0] pno_perm(input logic [IDX_W-1:0] idx);
      return PERM_TABLE[idx];
   endfunction

   // Gradient select: dot product of a corner offset with an edge vector from a 16-entry
   // table, chosen by the low four bits of the corner hash
   function automatic logic signed [GRAD_W-1:0] pno_grad(
      input logic [IDX_W-1:0]       h,
      input logic signed [FR_W-1:0] x,
      input logic signed [FR_W-1:0] y,
      input logic signed [FR_W-1:0] z
   );
      logic signed [GRAD_W-1:0] xe;
      logic signed [GRAD_W-1:0] ye;
      logic signed [GRAD_W-1:0] ze;
      logic signed [GRAD_W-1:0] res;
      xe = GRAD_W'(x);
      ye = GRAD_W'(y);
      ze = GRAD_W'(z);
      unique case (h[3:0])
         4'h0: res =  xe + ye;
         4'h1: res = -xe + ye;
         4'h2: res =  xe - ye;
         4'h3: res = -xe - ye;
         4'h4: res =  xe + ze;
         4'h5: res = -xe + ze;
         4'h6: res =  xe - ze;
         4'h7: res = -xe - ze;
         4'h8: res =  ye + ze;
         4'h9: res = -ye + ze;
         4'hA: res =  ye - ze;
         4'hB: res = -ye - ze;
         4'hC: res =  ye + xe;
         4'hD: res = -ye + ze;
         4'hE: res =  ye - xe;
         default: res = -ye - ze;
      endcase
      return res;
   endfunction

endpackage

### hdl/perlin_noise_3d_octaves_core.sv
`timescale 1ns / 1ps
// Top level of the fractal 3D Perlin noise core: sequencer around one shared
// multiplier. Depends on pno_pkg and pno_div.
//
// Usage:
//   Input channel req_*: one 3D point per transaction, signed Q16.16 per axis.
//   Result channel rsp_*: one signed Q2.16 noise value per point, saturated.
//   Config port csr_*: octave count (index 0) and persistence (index 1); the user
//   must write them only while the core is idle, which the core does not enforce.
// Sequence:
//   Each octave runs the hashing states S_HASH0 to S_HASH2, then steps through
//   the shared multiplier (the three quintic fades, the trilinear blend, the
//   weighted sum, the amplitude update). The final normalising divide runs in
//   the bit-serial divider, framed by the S_DIV, S_DIVW and S_DONE states. Only
//   one point is in flight at a time; the next point is accepted in the cycle
//   after the result is written, so a new point is never taken before the last
//   one's result is in the output register.
// Reset: synchronous; clears the sequencer and result valid, and loads
//   octave count 1 and persistence 0.5.
// Stall: a finished result waits in the output register; the next point is
//   accepted meanwhile, but a later result holds until the register is free.
module perlin_noise_3d_octaves_core #(
   parameter int MAX_OCTAVES = pno_pkg::MAX_OCTAVES_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [pno_pkg::POINT_W-1:0]       req_point_x,
   input  logic signed [pno_pkg::POINT_W-1:0]       req_point_y,
   input  logic signed [pno_pkg::POINT_W-1:0]       req_point_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [pno_pkg::NOISE_W-1:0]       rsp_noise_value,
   input  logic                                     csr_write_en,
   input  logic [pno_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [pno_pkg::CSR_DATA_W-1:0]           csr_wdata
);

   import pno_pkg::*;

   localparam int OCW    = $clog2(MAX_OCTAVES + 1);
   localparam int STEP_W = 5;

   // Multiplier steps within one octave
   localparam logic [STEP_W-1:0] ST_FADE_LAST = 5'd11;
   localparam logic [STEP_W-1:0] ST_LERP0     = 5'd12;
   localparam logic [STEP_W-1:0] ST_LERP1     = 5'd13;
   localparam logic [STEP_W-1:0] ST_LERP2     = 5'd14;
   localparam logic [STEP_W-1:0] ST_LERP3     = 5'd15;
   localparam logic [STEP_W-1:0] ST_LERP4     = 5'd16;
   localparam logic [STEP_W-1:0] ST_LERP5     = 5'd17;
   localparam logic [STEP_W-1:0] ST_LERP6     = 5'd18;
   localparam logic [STEP_W-1:0] ST_ACC       = 5'd19;
   localparam logic [STEP_W-1:0] ST_AMP       = 5'd20;

   typedef enum logic [2:0] {
      S_IDLE, S_HASH0, S_HASH1, S_HASH2, S_MUL, S_DIV, S_DIVW, S_DONE
   } state_type;

   state_type state_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [OCW-1:0]           oct_ff;
   logic [COORD_W-1:0]       cur_x_ff, cur_y_ff, cur_z_ff;
   logic [IDX_W-1:0]         ha_ff, hb_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [GRAD_W-1:0] g0_ff, g1_ff, g2_ff, g3_ff, g4_ff, g5_ff, g6_ff, g7_ff;
   logic signed [MUL_W-1:0]  fr_ff;
   logic signed [FR_W-1:0]   u_ff, v_ff, w_ff;
   logic [AMP_W-1:0]         amp_ff;
   logic [AMP_SUM_W-1:0]     amp_sum_ff;
   logic signed [TOTAL_W-1:0] total_ff;
   logic                     neg_ff;
   logic [OCT_CNT_W-1:0]     oct_cnt_ff;
   logic [PERSIST_W-1:0]     persist_ff;
   logic                     rsp_valid_ff;
   logic signed [NOISE_W-1:0] rsp_value_ff;

   logic signed [FR_W-1:0]   fx, fy, fz, fx1, fy1, fz1, fade_t;
   logic signed [GRAD_W-1:0] la, lb;
   logic signed [FR_W-1:0]   lt;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [SUM_W-1:0]  addend, sum;
   logic signed [PROD_W-1:0] prod;
   logic [OCW-1:0]           n_eff;
   logic                     oct_last;
   logic                     div_start, div_done;
   logic [TOTAL_W-1:0]       total_mag, div_quo;
   logic signed [NOISE_W-1:0] sat_value;

   // Cube fractions and their offsets to the far corner
   assign fx  = signed'({2'b00, cur_x_ff[FRAC_BITS-1:0]});
   assign fy  = signed'({2'b00, cur_y_ff[FRAC_BITS-1:0]});
   assign fz  = signed'({2'b00, cur_z_ff[FRAC_BITS-1:0]});
   assign fx1 = fx - FR_W'(ONE);
   assign fy1 = fy - FR_W'(ONE);
   assign fz1 = fz - FR_W'(ONE);

   // Clamp the configured octave count to the supported range
   always_comb begin
      if (oct_cnt_ff == '0) begin
         n_eff = OCW'(1);
      end else if (int'(oct_cnt_ff) > MAX_OCTAVES) begin
         n_eff = OCW'(MAX_OCTAVES);
      end else begin
         n_eff = OCW'(oct_cnt_ff);
      end
   end
   assign oct_last = (oct_ff == n_eff - OCW'(1));

   // Operand select for the shared multiplier
   always_comb begin
      la = '0;
      lb = '0;
      lt = '0;
      unique case (step_ff[3:2])
         2'd0:    fade_t = fx;
         2'd1:    fade_t = fy;
         default: fade_t = fz;
      endcase
      unique case (step_ff)
         ST_LERP0: begin la = g0_ff; lb = g1_ff; lt = u_ff; end
         ST_LERP1: begin la = g2_ff; lb = g3_ff; lt = u_ff; end
         ST_LERP2: begin la = g0_ff; lb = g2_ff; lt = v_ff; end
         ST_LERP3: begin la = g4_ff; lb = g5_ff; lt = u_ff; end
         ST_LERP4: begin la = g6_ff; lb = g7_ff; lt = u_ff; end
         ST_LERP5: begin la = g4_ff; lb = g6_ff; lt = v_ff; end
         ST_LERP6: begin la = g0_ff; lb = g4_ff; lt = w_ff; end
         default: ;
      endcase

      mul_a  = '0;
      mul_b  = '0;
      addend = '0;
      if (step_ff <= ST_FADE_LAST) begin
         if (step_ff[1:0] == 2'd0) begin
            // t * (6t - 15) + 10, first Horner step of the quintic fade
            mul_a  = MUL_W'(fade_t);
            mul_b  = (MUL_W'(fade_t) <<< 2) + (MUL_W'(fade_t) <<< 1) - MUL_W'(15 * ONE);
            addend = SUM_W'(10 * ONE);
         end else begin
            mul_a = fr_ff;
            mul_b = MUL_W'(fade_t);
         end
      end else if (step_ff == ST_ACC) begin
         mul_a = MUL_W'(g0_ff);
         mul_b = MUL_W'(signed'({1'b0, amp_ff}));
      end else if (step_ff == ST_AMP) begin
         mul_a = MUL_W'(signed'({1'b0, amp_ff}));
         mul_b = MUL_W'(signed'({1'b0, persist_ff}));
      end else begin
         // a + t * (b - a)
         mul_a  = MUL_W'(lt);
         mul_b  = MUL_W'(lb) - MUL_W'(la);
         addend = SUM_W'(la);
      end
   end

   assign prod = mul_a * mul_b;
   assign sum  = signed'(prod[PROD_W-1:FRAC_BITS]) + addend;

   // Normalising divide on magnitudes
   assign total_mag = total_ff[TOTAL_W-1] ? TOTAL_W'(-total_ff) : TOTAL_W'(total_ff);
   assign div_start = (state_ff == S_DIV);

   pno_div #(
      .NUM_W (TOTAL_W),
      .DEN_W (AMP_SUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (total_mag),
      .den   (amp_sum_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Restore the sign and saturate to Q2.16
   always_comb begin
      if (!neg_ff && div_quo > TOTAL_W'(NOISE_MAX)) begin
         sat_value = NOISE_W'(NOISE_MAX);
      end else if (neg_ff && div_quo > TOTAL_W'(NOISE_MIN_MAG)) begin
         sat_value = NOISE_W'(-NOISE_MIN_MAG);
      end else if (neg_ff) begin
         sat_value = -signed'(div_quo[NOISE_W-1:0]);
      end else begin
         sat_value = signed'(div_quo[NOISE_W-1:0]);
      end
   end

   // Sequencer, datapath registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         oct_cnt_ff   <= OCT_CNT_RESET;
         persist_ff   <= PERSIST_RESET;
         step_ff      <= '0;
         oct_ff       <= '0;
      end else begin
         // Configuration writes
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_OCTAVE_COUNT: oct_cnt_ff <= csr_wdata[OCT_CNT_W-1:0];
               CSR_PERSISTENCE:  persist_ff <= csr_wdata[PERSIST_W-1:0];
            endcase
         end

         // Drop the result once taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cur_x_ff   <= req_point_x[COORD_W-1:0];
                  cur_y_ff   <= req_point_y[COORD_W-1:0];
                  cur_z_ff   <= req_point_z[COORD_W-1:0];
                  total_ff   <= '0;
                  amp_sum_ff <= '0;
                  amp_ff     <= AMP_W'(ONE);
                  oct_ff     <= '0;
                  state_ff   <= S_HASH0;
               end
            end
            S_HASH0: begin
               ha_ff <= pno_perm(cur_x_ff[COORD_W-1:FRAC_BITS])
                        + cur_y_ff[COORD_W-1:FRAC_BITS];
               hb_ff <= pno_perm(cur_x_ff[COORD_W-1:FRAC_BITS] + IDX_W'(1))
                        + cur_y_ff[COORD_W-1:FRAC_BITS];
               state_ff <= S_HASH1;
            end
            S_HASH1: begin
               aa_ff <= pno_perm(ha_ff) + cur_z_ff[COORD_W-1:FRAC_BITS];
               ab_ff <= pno_perm(ha_ff + IDX_W'(1)) + cur_z_ff[COORD_W-1:FRAC_BITS];
               ba_ff <= pno_perm(hb_ff) + cur_z_ff[COORD_W-1:FRAC_BITS];
               bb_ff <= pno_perm(hb_ff + IDX_W'(1)) + cur_z_ff[COORD_W-1:FRAC_BITS];
               state_ff <= S_HASH2;
            end
            S_HASH2: begin
               // Gradients at the eight cube corners
               g0_ff <= pno_grad(pno_perm(aa_ff), fx,  fy,  fz);
               g1_ff <= pno_grad(pno_perm(ba_ff), fx1, fy,  fz);
               g2_ff <= pno_grad(pno_perm(ab_ff), fx,  fy1, fz);
               g3_ff <= pno_grad(pno_perm(bb_ff), fx1, fy1, fz);
               g4_ff <= pno_grad(pno_perm(aa_ff + IDX_W'(1)), fx,  fy,  fz1);
               g5_ff <= pno_grad(pno_perm(ba_ff + IDX_W'(1)), fx1, fy,  fz1);
               g6_ff <= pno_grad(pno_perm(ab_ff + IDX_W'(1)), fx,  fy1, fz1);
               g7_ff <= pno_grad(pno_perm(bb_ff + IDX_W'(1)), fx1, fy1, fz1);
               step_ff  <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff <= ST_FADE_LAST) begin
                  fr_ff <= MUL_W'(sum);
                  if (step_ff[1:0] == 2'd3) begin
                     unique case (step_ff[3:2])
                        2'd0:    u_ff <= FR_W'(sum);
                        2'd1:    v_ff <= FR_W'(sum);
                        default: w_ff <= FR_W'(sum);
                     endcase
                  end
               end else begin
                  unique case (step_ff)
                     ST_LERP0, ST_LERP2, ST_LERP6: g0_ff <= GRAD_W'(sum);
                     ST_LERP1:                     g2_ff <= GRAD_W'(sum);
                     ST_LERP3, ST_LERP5:           g4_ff <= GRAD_W'(sum);
                     ST_LERP4:                     g6_ff <= GRAD_W'(sum);
                     ST_ACC: begin
                        total_ff   <= total_ff + TOTAL_W'(prod);
                        amp_sum_ff <= amp_sum_ff + AMP_SUM_W'(amp_ff);
                     end
                     ST_AMP: begin
                        amp_ff <= prod[FRAC_BITS+AMP_W-1:FRAC_BITS];
                        if (oct_last) begin
                           state_ff <= S_DIV;
                        end else begin
                           // Advance to the next octave at twice the frequency
                           oct_ff   <= oct_ff + OCW'(1);
                           cur_x_ff <= cur_x_ff << 1;
                           cur_y_ff <= cur_y_ff << 1;
                           cur_z_ff <= cur_z_ff << 1;
                           state_ff <= S_HASH0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_DIV: begin
               neg_ff   <= total_ff[TOTAL_W-1];
               state_ff <= S_DIVW;
            end
            S_DIVW: begin
               if (div_done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // Hold until the result register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_value_ff <= sat_value;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("core ready right after accepting a transaction");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVW)
      else $error("divider finished outside the wait state");

   a_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      div_start |-> amp_sum_ff != '0)
      else $error("amplitude sum is zero at divide start");

   a_octave_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> oct_ff < n_eff)
      else $error("octave index beyond the configured count");

endmodule

### hdl/pno_div.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module pno_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [DEN_W:0]   rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   rem_sh;
   logic             ge;

   // Bring down the next dividend bit and try the subtract
   assign rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= num;
            den_ff  <= den;
            cnt_ff  <= CW'(NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
            quo_ff <= {quo_ff[NUM_W-2:0], ge};
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
